@@ src/keyed_linked_deque_macros.svh @@
// assertion macros for the keyed linked deque
// no dependencies
`ifndef KEYED_LINKED_DEQUE_MACROS_SVH
`define KEYED_LINKED_DEQUE_MACROS_SVH
`ifndef SYNTHESIS
`define KLD_ASSERT_IMP(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("assertion failed");
`define KLD_ASSERT_NXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("assertion failed");
`else
`define KLD_ASSERT_IMP(label, clk, rst, a, c)
`define KLD_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

@@ src/kld_pkg.sv @@
// shared codes for the keyed linked deque
// no dependencies
package kld_pkg;
   localparam logic [3:0] ACT_PUSH_TAIL = 4'd0;
   localparam logic [3:0] ACT_PUSH_HEAD = 4'd1;
   localparam logic [3:0] ACT_POP_TAIL  = 4'd2;
   localparam logic [3:0] ACT_POP_HEAD  = 4'd3;
   localparam logic [3:0] ACT_FIND      = 4'd4;
   localparam logic [3:0] ACT_REMOVE    = 4'd5;
   localparam logic [3:0] ACT_CUR_HEAD  = 4'd6;
   localparam logic [3:0] ACT_CUR_TAIL  = 4'd7;
   localparam logic [3:0] ACT_READ_ADV  = 4'd8;
   localparam logic [3:0] ACT_STEP_BACK = 4'd9;
   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_FULL  = 3'd1;
   localparam logic [2:0] ST_EMPTY = 3'd2;
   localparam logic [2:0] ST_NOKEY = 3'd3;
   localparam logic [2:0] ST_NOCUR = 3'd4;
endpackage

@@ src/keyed_linked_deque.sv @@
// keyed linked deque over one node memory; depends on kld_pkg and the macros header
// an accepted item goes through S_EXEC, S_FIX per neighbor link fix (push beside an entry
// or unlink at an end fixes one neighbor, unlink in the middle both), S_BACK for a step
// back onto an entry, and S_RESP; find stays in S_EXEC over entries up to the match or
// the list end; one item in flight, next item taken the cycle after the result loads;
// synchronous active-high reset clears pointers, counts and rsp_valid, not the memory
`include "keyed_linked_deque_macros.svh"
module keyed_linked_deque #(
   parameter int NODES = 64,
   parameter int PAYLOAD_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [3:0]  req_action,
   input  logic [15:0] req_key,
   input  logic [31:0] req_payload,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [15:0] rsp_key_out,
   output logic [31:0] rsp_payload_out,
   output logic [6:0]  rsp_entry_count,
   output logic        rsp_cursor_valid
);
   localparam int AW = $clog2(NODES);
   localparam int PW = AW + 1;
   localparam logic [PW-1:0] NIL = PW'(NODES);

   typedef struct packed {
      logic [PW-1:0] nxt;
      logic [PW-1:0] prv;
      logic [15:0] key;
      logic [PAYLOAD_WIDTH-1:0] pay;
   } node_type;

   typedef enum logic [2:0] {S_IDLE, S_EXEC, S_FIX, S_BACK, S_RESP} state_type;

   function automatic logic is_ent(logic [PW-1:0] p);
      return p < NIL;
   endfunction

   // node memory with write enables for nxt, prv and key/payload, and a registered read
   node_type mem [NODES];
   node_type rd_ff;
   logic rd_en;
   logic [AW-1:0] rd_addr;
   logic we_nxt, we_prv, we_dat;
   logic [AW-1:0] wa;
   node_type wd;
   always_ff @(posedge clock) begin
      if (we_nxt) mem[wa].nxt <= wd.nxt;
      if (we_prv) mem[wa].prv <= wd.prv;
      if (we_dat) begin
         mem[wa].key <= wd.key;
         mem[wa].pay <= wd.pay;
      end
      if (rd_en) rd_ff <= mem[rd_addr];
   end

   state_type state_ff, state_in;
   logic [3:0] act_ff, act_in;
   logic [15:0] key_ff, key_in;
   logic [PAYLOAD_WIDTH-1:0] pay_ff, pay_in;
   logic [PW-1:0] head_ff, head_in, tail_ff, tail_in, cur_ff, cur_in;
   logic [PW-1:0] free_ff, free_in, fresh_ff, fresh_in, cnt_ff, cnt_in;
   logic [PW-1:0] addr_ff, addr_in, n_ff, n_in;
   // pending neighbor link fixes: prev.nxt <= lx and next.prv <= lp
   logic fp_ff, fp_in, fx_ff, fx_in;
   logic [PW-1:0] lp_ff, lp_in, lx_ff, lx_in;
   logic [2:0] st_ff, st_in;
   logic [15:0] ko_ff, ko_in;
   logic [PAYLOAD_WIDTH-1:0] po_ff, po_in;
   // result register
   logic vld_ff, vld_in;
   logic [2:0] ost_ff, ost_in;
   logic [15:0] oko_ff, oko_in;
   logic [31:0] opo_ff, opo_in;
   logic [6:0] ocnt_ff, ocnt_in;
   logic ocv_ff, ocv_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = vld_ff;
   assign rsp_status = ost_ff;
   assign rsp_key_out = oko_ff;
   assign rsp_payload_out = opo_ff;
   assign rsp_entry_count = ocnt_ff;
   assign rsp_cursor_valid = ocv_ff;

   // sequencer: one item at a time, read then write back on the node memory
   always_comb begin
      logic [PW-1:0] e;
      node_type nd;
      e = NIL;
      nd = rd_ff;
      state_in = state_ff; act_in = act_ff; key_in = key_ff; pay_in = pay_ff;
      head_in = head_ff; tail_in = tail_ff; cur_in = cur_ff; free_in = free_ff;
      fresh_in = fresh_ff; cnt_in = cnt_ff; addr_in = addr_ff; n_in = n_ff;
      fp_in = fp_ff; fx_in = fx_ff; lp_in = lp_ff; lx_in = lx_ff;
      st_in = st_ff; ko_in = ko_ff; po_in = po_ff;
      vld_in = vld_ff; ost_in = ost_ff; oko_in = oko_ff; opo_in = opo_ff;
      ocnt_in = ocnt_ff; ocv_in = ocv_ff;
      rd_en = 1'b0; rd_addr = '0;
      we_nxt = 1'b0; we_prv = 1'b0; we_dat = 1'b0; wa = '0; wd = '0;
      if (vld_ff && rsp_ready) vld_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               act_in = req_action; key_in = req_key;
               pay_in = PAYLOAD_WIDTH'(req_payload);
               st_in = kld_pkg::ST_OK; ko_in = '0; po_in = '0;
               fp_in = 1'b0; fx_in = 1'b0; n_in = '0;
               state_in = S_EXEC;
               case (req_action)
                  kld_pkg::ACT_PUSH_TAIL, kld_pkg::ACT_PUSH_HEAD: addr_in = free_ff;
                  kld_pkg::ACT_POP_TAIL: addr_in = tail_ff;
                  kld_pkg::ACT_POP_HEAD, kld_pkg::ACT_FIND: addr_in = head_ff;
                  default: addr_in = cur_ff;
               endcase
               rd_en = is_ent(addr_in); rd_addr = AW'(addr_in);
            end
         end
         S_EXEC: begin
            state_in = S_RESP;
            case (act_ff)
               kld_pkg::ACT_PUSH_TAIL, kld_pkg::ACT_PUSH_HEAD: begin
                  if (cnt_ff >= NIL) st_in = kld_pkg::ST_FULL;
                  else begin
                     if (is_ent(free_ff)) begin
                        e = free_ff; free_in = nd.nxt;
                     end else if (fresh_ff < NIL) begin
                        e = fresh_ff; fresh_in = fresh_ff + 1'b1;
                     end
                     if (!is_ent(e)) st_in = kld_pkg::ST_FULL;
                     else begin
                        we_nxt = 1'b1; we_prv = 1'b1; we_dat = 1'b1; wa = AW'(e);
                        wd.key = key_ff; wd.pay = pay_ff;
                        if (act_ff == kld_pkg::ACT_PUSH_TAIL) begin
                           wd.nxt = NIL; wd.prv = tail_ff;
                           lp_in = tail_ff; lx_in = e; fp_in = is_ent(tail_ff);
                           if (!is_ent(tail_ff)) head_in = e;
                           tail_in = e;
                        end else begin
                           wd.prv = NIL; wd.nxt = head_ff;
                           lp_in = e; lx_in = head_ff; fx_in = is_ent(head_ff);
                           if (!is_ent(head_ff)) tail_in = e;
                           head_in = e;
                        end
                        cur_in = e; cnt_in = cnt_ff + 1'b1;
                     end
                  end
               end
               kld_pkg::ACT_POP_TAIL, kld_pkg::ACT_POP_HEAD, kld_pkg::ACT_REMOVE: begin
                  if (cnt_ff == '0 || (act_ff != kld_pkg::ACT_REMOVE && !is_ent(addr_ff)))
                     st_in = kld_pkg::ST_EMPTY;
                  else if (!is_ent(addr_ff)) st_in = kld_pkg::ST_NOCUR;
                  else begin
                     ko_in = nd.key; po_in = nd.pay;
                     // removed entry goes to the free list
                     we_nxt = 1'b1; wa = AW'(addr_ff); wd.nxt = free_ff;
                     free_in = addr_ff;
                     if (cur_ff == addr_ff) cur_in = NIL;
                     cnt_in = cnt_ff - 1'b1;
                     lp_in = nd.prv; lx_in = nd.nxt;
                     fp_in = is_ent(nd.prv); fx_in = is_ent(nd.nxt);
                     if (!is_ent(nd.prv)) head_in = nd.nxt;
                     if (!is_ent(nd.nxt)) tail_in = nd.prv;
                  end
               end
               kld_pkg::ACT_FIND: begin
                  if (n_ff < cnt_ff && is_ent(addr_ff)) begin
                     if (nd.key == key_ff) begin
                        cur_in = addr_ff; ko_in = nd.key; po_in = nd.pay;
                     end else begin
                        // step to the next entry, one per cycle
                        addr_in = nd.nxt; n_in = n_ff + 1'b1;
                        rd_en = is_ent(nd.nxt); rd_addr = AW'(nd.nxt);
                        state_in = S_EXEC;
                     end
                  end else begin
                     st_in = kld_pkg::ST_NOKEY; cur_in = NIL;
                  end
               end
               kld_pkg::ACT_CUR_HEAD: begin
                  cur_in = head_ff;
                  if (!is_ent(head_ff)) st_in = kld_pkg::ST_EMPTY;
               end
               kld_pkg::ACT_CUR_TAIL: begin
                  cur_in = tail_ff;
                  if (!is_ent(tail_ff)) st_in = kld_pkg::ST_EMPTY;
               end
               kld_pkg::ACT_READ_ADV: begin
                  if (!is_ent(cur_ff)) st_in = kld_pkg::ST_NOCUR;
                  else begin
                     ko_in = nd.key; po_in = nd.pay; cur_in = nd.nxt;
                  end
               end
               kld_pkg::ACT_STEP_BACK: begin
                  if (!is_ent(cur_ff)) st_in = kld_pkg::ST_NOCUR;
                  else begin
                     cur_in = nd.prv;
                     if (is_ent(nd.prv)) begin
                        // fetch the previous entry for its contents
                        rd_en = 1'b1; rd_addr = AW'(nd.prv); state_in = S_BACK;
                     end
                  end
               end
               default: ;
            endcase
            if (fp_in || fx_in) state_in = S_FIX;
         end
         S_FIX: begin
            // one neighbor link write per cycle
            if (fp_ff) begin
               we_nxt = 1'b1; wa = AW'(lp_ff); wd.nxt = lx_ff; fp_in = 1'b0;
               if (!fx_ff) state_in = S_RESP;
            end else begin
               we_prv = 1'b1; wa = AW'(lx_ff); wd.prv = lp_ff; fx_in = 1'b0;
               state_in = S_RESP;
            end
         end
         S_BACK: begin
            ko_in = rd_ff.key; po_in = rd_ff.pay; state_in = S_RESP;
         end
         S_RESP: begin
            // load the result register once it is free
            if (!vld_ff || rsp_ready) begin
               vld_in = 1'b1; ost_in = st_ff; oko_in = ko_ff; opo_in = 32'(po_ff);
               ocnt_in = 7'(cnt_ff); ocv_in = is_ent(cur_ff);
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; head_ff <= NIL; tail_ff <= NIL; cur_ff <= NIL;
         free_ff <= NIL; fresh_ff <= '0; cnt_ff <= '0; vld_ff <= 1'b0;
         fp_ff <= 1'b0; fx_ff <= 1'b0;
      end else begin
         state_ff <= state_in; head_ff <= head_in; tail_ff <= tail_in;
         cur_ff <= cur_in; free_ff <= free_in; fresh_ff <= fresh_in;
         cnt_ff <= cnt_in; vld_ff <= vld_in; fp_ff <= fp_in; fx_ff <= fx_in;
      end
      act_ff <= act_in; key_ff <= key_in; pay_ff <= pay_in; addr_ff <= addr_in;
      n_ff <= n_in; lp_ff <= lp_in; lx_ff <= lx_in; st_ff <= st_in;
      ko_ff <= ko_in; po_ff <= po_in; ost_ff <= ost_in; oko_ff <= oko_in;
      opo_ff <= opo_in; ocnt_ff <= ocnt_in; ocv_ff <= ocv_in;
   end

   `KLD_ASSERT_IMP(a_count_range, clock, reset, 1'b1, cnt_ff <= NIL)
   `KLD_ASSERT_IMP(a_empty_ptrs, clock, reset, cnt_ff == '0, !is_ent(head_ff) && !is_ent(tail_ff))
   `KLD_ASSERT_IMP(a_cur_live, clock, reset, is_ent(cur_ff), cnt_ff != '0)
   `KLD_ASSERT_NXT(a_rsp_hold, clock, reset, vld_ff && !rsp_ready, vld_ff)
   `KLD_ASSERT_NXT(a_rsp_stable, clock, reset, vld_ff && !rsp_ready, $stable(opo_ff))
endmodule

@@ bench/tb_keyed_linked_deque.sv @@
// testbench for the keyed linked deque: directed and random request items,
// predicted with a local list model and checked field by field on the rsp side
// depends on kld_pkg and keyed_linked_deque
`timescale 1ns / 1ps
module tb_keyed_linked_deque;
   localparam int NODES = 64;
   localparam logic [6:0] NIL = 7'd64;
   localparam logic [3:0] ACT_NOP_LO = 4'd10;
   localparam logic [3:0] ACT_NOP_HI = 4'd15;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [3:0]  req_action = '0;
   logic [15:0] req_key = '0;
   logic [31:0] req_payload = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [15:0] rsp_key_out;
   logic [31:0] rsp_payload_out;
   logic [6:0]  rsp_entry_count;
   logic        rsp_cursor_valid;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] key_out;
      logic [31:0] payload_out;
      logic [6:0]  entry_count;
      logic        cursor_valid;
   } deque_rsp_type;

   deque_rsp_type pending_rsp[$];
   int         error_count = 0;
   bit         long_hold = 1'b0;
   bit         hold_done = 1'b0;

   // list model state
   logic [6:0]  nxt_m[NODES];
   logic [6:0]  prv_m[NODES];
   logic [15:0] key_m[NODES];
   logic [31:0] pay_m[NODES];
   logic [6:0]  head_m, tail_m, cur_m, free_m, fresh_m, count_m;

   keyed_linked_deque u_dut (.*);

   always #2 clock = ~clock;

   task automatic model_reset();
      head_m = NIL; tail_m = NIL; cur_m = NIL; free_m = NIL;
      fresh_m = '0; count_m = '0;
   endtask

   function automatic bit live(logic [6:0] p);
      return p < NIL;
   endfunction

   task automatic model_unlink(input logic [6:0] e, inout deque_rsp_type r);
      logic [6:0] p, x;
      p = prv_m[e];
      x = nxt_m[e];
      r.key_out = key_m[e];
      r.payload_out = pay_m[e];
      if (live(p)) nxt_m[p] = x; else head_m = x;
      if (live(x)) prv_m[x] = p; else tail_m = p;
      if (cur_m == e) cur_m = NIL;
      nxt_m[e] = free_m;
      free_m = e;
      if (count_m > 0) count_m--;
   endtask

   task automatic model_push(input bit at_tail, input logic [15:0] k,
                             input logic [31:0] pl, inout deque_rsp_type r);
      logic [6:0] e;
      e = NIL;
      if (count_m >= NIL) begin
         r.status = kld_pkg::ST_FULL;
         return;
      end
      if (live(free_m)) begin
         e = free_m;
         free_m = nxt_m[e];
      end else if (fresh_m < NIL) begin
         e = fresh_m;
         fresh_m++;
      end
      if (!live(e)) begin
         r.status = kld_pkg::ST_FULL;
         return;
      end
      key_m[e] = k;
      pay_m[e] = pl;
      if (at_tail) begin
         nxt_m[e] = NIL;
         prv_m[e] = tail_m;
         if (live(tail_m)) nxt_m[tail_m] = e; else head_m = e;
         tail_m = e;
      end else begin
         prv_m[e] = NIL;
         nxt_m[e] = head_m;
         if (live(head_m)) prv_m[head_m] = e; else tail_m = e;
         head_m = e;
      end
      cur_m = e;
      count_m++;
   endtask

   // compute the expected result of one accepted item
   task automatic predict_deque(input logic [3:0] act, input logic [15:0] k,
                                input logic [31:0] pl);
      deque_rsp_type r;
      logic [6:0] e;
      int n;
      r = '0;
      r.status = kld_pkg::ST_OK;
      case (act)
         kld_pkg::ACT_PUSH_TAIL: model_push(1'b1, k, pl, r);
         kld_pkg::ACT_PUSH_HEAD: model_push(1'b0, k, pl, r);
         kld_pkg::ACT_POP_TAIL: begin
            if (count_m == 0 || !live(tail_m)) r.status = kld_pkg::ST_EMPTY;
            else model_unlink(tail_m, r);
         end
         kld_pkg::ACT_POP_HEAD: begin
            if (count_m == 0 || !live(head_m)) r.status = kld_pkg::ST_EMPTY;
            else model_unlink(head_m, r);
         end
         kld_pkg::ACT_FIND: begin
            r.status = kld_pkg::ST_NOKEY;
            e = head_m;
            cur_m = NIL;
            for (n = 0; n < count_m && live(e); n++) begin
               if (key_m[e] == k) begin
                  cur_m = e;
                  r.key_out = key_m[e];
                  r.payload_out = pay_m[e];
                  r.status = kld_pkg::ST_OK;
                  break;
               end
               e = nxt_m[e];
            end
         end
         kld_pkg::ACT_REMOVE: begin
            if (count_m == 0) r.status = kld_pkg::ST_EMPTY;
            else if (!live(cur_m)) r.status = kld_pkg::ST_NOCUR;
            else model_unlink(cur_m, r);
         end
         kld_pkg::ACT_CUR_HEAD: begin
            cur_m = head_m;
            if (!live(cur_m)) r.status = kld_pkg::ST_EMPTY;
         end
         kld_pkg::ACT_CUR_TAIL: begin
            cur_m = tail_m;
            if (!live(cur_m)) r.status = kld_pkg::ST_EMPTY;
         end
         kld_pkg::ACT_READ_ADV: begin
            if (!live(cur_m)) r.status = kld_pkg::ST_NOCUR;
            else begin
               r.key_out = key_m[cur_m];
               r.payload_out = pay_m[cur_m];
               cur_m = nxt_m[cur_m];
            end
         end
         kld_pkg::ACT_STEP_BACK: begin
            if (!live(cur_m)) r.status = kld_pkg::ST_NOCUR;
            else begin
               cur_m = prv_m[cur_m];
               if (live(cur_m)) begin
                  r.key_out = key_m[cur_m];
                  r.payload_out = pay_m[cur_m];
               end
            end
         end
         default: ;
      endcase
      r.entry_count = count_m;
      r.cursor_valid = live(cur_m);
      pending_rsp.push_back(r);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // send one item, with a random gap before it now and then
   task automatic send_item(input logic [3:0] act, input logic [15:0] k,
                            input logic [31:0] pl);
      if ($urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_key <= k;
      req_payload <= pl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_deque(act, k, pl);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // receiver stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) rsp_ready <= 1'b0;
      else if (long_hold) rsp_ready <= 1'b0;
      else rsp_ready <= ($urandom_range(0, 3) != 0);
   end

   // check each accepted result against the oldest expectation
   always @(posedge clock) begin
      deque_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("unexpected item", 32'(rsp_status), 32'hffff_ffff);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status)
               report_mismatch("status", 32'(rsp_status), 32'(want.status));
            if (rsp_key_out !== want.key_out)
               report_mismatch("key_out", 32'(rsp_key_out), 32'(want.key_out));
            if (rsp_payload_out !== want.payload_out)
               report_mismatch("payload_out", rsp_payload_out, want.payload_out);
            if (rsp_entry_count !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_entry_count),
                               32'(want.entry_count));
            if (rsp_cursor_valid !== want.cursor_valid)
               report_mismatch("cursor_valid", 32'(rsp_cursor_valid),
                               32'(want.cursor_valid));
         end
      end
   end

   // long receiver hold-off once, counted in cycles
   initial begin
      wait (hold_done);
      long_hold = 1'b1;
      repeat (400) @(posedge clock);
      long_hold = 1'b0;
   end

   function automatic logic [15:0] pick_key();
      // small key space so finds hit often; sometimes full range
      return ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 15));
   endfunction

   task automatic test_empty_cases();
      send_item(kld_pkg::ACT_POP_TAIL, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_POP_HEAD, 16'hffff, 32'hffff_ffff);
      send_item(kld_pkg::ACT_REMOVE, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_FIND, 16'h1234, 32'h0);
      send_item(kld_pkg::ACT_CUR_HEAD, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_CUR_TAIL, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_READ_ADV, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_STEP_BACK, 16'h0, 32'h0);
      send_item(ACT_NOP_HI, 16'h0, 32'h0);
   endtask

   task automatic test_basic_ops();
      send_item(kld_pkg::ACT_PUSH_TAIL, 16'hffff, 32'hffff_ffff);
      send_item(kld_pkg::ACT_PUSH_HEAD, 16'h0000, 32'h0000_0000);
      send_item(kld_pkg::ACT_PUSH_TAIL, 16'h5a5a, 32'ha5a5_5a5a);
      send_item(kld_pkg::ACT_CUR_HEAD, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_READ_ADV, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_STEP_BACK, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_STEP_BACK, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_CUR_TAIL, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_READ_ADV, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_FIND, 16'hffff, 32'h0);
      send_item(kld_pkg::ACT_REMOVE, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_REMOVE, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_FIND, 16'h7777, 32'h0);
      send_item(kld_pkg::ACT_POP_HEAD, 16'h0, 32'h0);
      send_item(kld_pkg::ACT_POP_TAIL, 16'h0, 32'h0);
      send_item(ACT_NOP_LO, 16'h0, 32'h0);
   endtask

   // fill past capacity while the receiver holds off, then drain
   task automatic test_full_pool();
      int i;
      hold_done = 1'b1;
      for (i = 0; i < NODES + 3; i++)
         send_item($urandom_range(0, 1) ? kld_pkg::ACT_PUSH_TAIL : kld_pkg::ACT_PUSH_HEAD,
                   pick_key(), $urandom);
      for (i = 0; i < 20; i++)
         send_item(kld_pkg::ACT_FIND, pick_key(), $urandom);
      for (i = 0; i < NODES + 2; i++)
         send_item($urandom_range(0, 1) ? kld_pkg::ACT_POP_TAIL : kld_pkg::ACT_POP_HEAD,
                   16'($urandom), $urandom);
   endtask

   task automatic test_random();
      int i, burst;
      logic [3:0] act;
      i = 0;
      while (i < 750) begin
         burst = $urandom_range(1, 30);
         repeat (burst) begin
            case ($urandom_range(0, 9))
               0, 1, 2: act = $urandom_range(0, 1) ? kld_pkg::ACT_PUSH_HEAD
                                                   : kld_pkg::ACT_PUSH_TAIL;
               3: act = $urandom_range(0, 1) ? kld_pkg::ACT_POP_HEAD
                                             : kld_pkg::ACT_POP_TAIL;
               4: act = kld_pkg::ACT_FIND;
               5: act = kld_pkg::ACT_REMOVE;
               6: act = $urandom_range(0, 1) ? kld_pkg::ACT_CUR_TAIL
                                             : kld_pkg::ACT_CUR_HEAD;
               7, 8: act = $urandom_range(0, 1) ? kld_pkg::ACT_STEP_BACK
                                                : kld_pkg::ACT_READ_ADV;
               default: act = 4'($urandom);
            endcase
            send_item(act, pick_key(), $urandom);
            i++;
         end
         if ($urandom_range(0, 1)) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   endtask

   initial begin
      model_reset();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_cases();
      test_basic_ops();
      test_full_pool();
      test_random();
      go_idle();
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL");
      $finish;
   end
endmodule
